// ===== hdl/ialu_pkg.sv =====
// Shared types and codes for the integer ALU with GCD and LCM.
// Used by ialu_engine and integer_alu_with_gcd_lcm_core; depends on nothing.
`default_nettype none

package ialu_pkg;

    localparam int DATA_WIDTH_DEF = 32;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_QUO = 3'd3;
    localparam logic [2:0] OP_REM = 3'd4;
    localparam logic [2:0] OP_GCD = 3'd5;
    localparam logic [2:0] OP_LCM = 3'd6;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_DIVZ   = 2'd1;
    localparam logic [1:0] ST_NONPOS = 2'd2;
    localparam logic [1:0] ST_UNUSED = 2'd3;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } ialu_req_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [1:0]         status_code;
    } ialu_rsp_t;

    typedef struct packed {
        logic start;
        logic take;
    } ialu_ctl_t;

    typedef struct packed {
        logic idle;
        logic done;
    } ialu_sts_t;

endpackage

`default_nettype wire

// ===== hdl/ialu_engine.sv =====
// Sequencer and datapath of the integer ALU around one shared add/subtract unit.
// Depends on ialu_pkg for request, response and control types.
`default_nettype none

module ialu_engine #(
    parameter int DATA_WIDTH = ialu_pkg::DATA_WIDTH_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  ialu_pkg::ialu_ctl_t  ctl,
    input  ialu_pkg::ialu_req_t  req,
    output ialu_pkg::ialu_sts_t  sts,
    output ialu_pkg::ialu_rsp_t  rsp
);

    localparam int DW = DATA_WIDTH;
    localparam int CW = $clog2(DW) + 1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ARITH = 4'd1;
    localparam logic [3:0] S_ABSA  = 4'd2;
    localparam logic [3:0] S_ABSB  = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_FIX   = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_GTWO  = 4'd7;
    localparam logic [3:0] S_GODD  = 4'd8;
    localparam logic [3:0] S_GLOOP = 4'd9;
    localparam logic [3:0] S_GSHL  = 4'd10;
    localparam logic [3:0] S_DONE  = 4'd11;

    logic [3:0]    state_reg, state_next;
    logic [2:0]    op_reg, op_next;
    logic [1:0]    st_reg, st_next;
    logic [DW-1:0] a_reg, a_next;
    logic [DW-1:0] b_reg, b_next;
    logic [DW-1:0] x_reg, x_next;
    logic [DW-1:0] y_reg, y_next;
    logic [DW-1:0] z_reg, z_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] sh_reg, sh_next;

    logic [63:0]   a_ext, b_ext;
    logic [DW-1:0] a_in, b_in;
    logic [DW:0]   ua, ub, us;
    logic          sub;
    logic          neg_a, neg_b, qbit;
    logic [DW+31:0] z_ext;

    assign a_ext = {32'b0, req.operand_a};
    assign b_ext = {32'b0, req.operand_b};
    assign a_in  = a_ext[DW-1:0];
    assign b_in  = b_ext[DW-1:0];
    assign neg_a = a_reg[DW-1];
    assign neg_b = b_reg[DW-1];

    // shared unit
    assign us   = ua + (sub ? ~ub : ub) + {{DW{1'b0}}, sub};
    assign qbit = ~us[DW];

    always_comb
    begin
        ua  = '0;
        ub  = '0;
        sub = 1'b0;
        unique case (state_reg)
            S_ARITH:
            begin
                ua  = {1'b0, a_reg};
                ub  = {1'b0, b_reg};
                sub = (op_reg == ialu_pkg::OP_SUB);
            end
            S_ABSA:
            begin
                ub  = {1'b0, x_reg};
                sub = 1'b1;
            end
            S_ABSB:
            begin
                ub  = {1'b0, y_reg};
                sub = 1'b1;
            end
            S_DIV:
            begin
                ua  = {z_reg, x_reg[DW-1]};
                ub  = {1'b0, y_reg};
                sub = 1'b1;
            end
            S_FIX:
            begin
                if (op_reg == ialu_pkg::OP_QUO)
                begin
                    ub  = {1'b0, x_reg};
                    sub = neg_a ^ neg_b;
                end
                else
                begin
                    ub  = {1'b0, z_reg};
                    sub = neg_a;
                end
            end
            S_MUL:
            begin
                ua = {1'b0, z_reg};
                ub = {1'b0, y_reg};
            end
            S_GLOOP:
            begin
                ua  = {1'b0, y_reg};
                ub  = {1'b0, x_reg};
                sub = 1'b1;
            end
            default:
            begin
                ua  = '0;
                ub  = '0;
                sub = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        st_next    = st_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        cnt_next   = cnt_reg;
        sh_next    = sh_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (ctl.start)
                begin
                    op_next  = req.opcode;
                    st_next  = ialu_pkg::ST_OK;
                    a_next   = a_in;
                    b_next   = b_in;
                    x_next   = a_in;
                    y_next   = b_in;
                    z_next   = '0;
                    cnt_next = '0;
                    sh_next  = '0;
                    priority case (req.opcode)
                        ialu_pkg::OP_ADD, ialu_pkg::OP_SUB:
                            state_next = S_ARITH;
                        ialu_pkg::OP_MUL:
                            state_next = S_MUL;
                        ialu_pkg::OP_QUO, ialu_pkg::OP_REM:
                        begin
                            if (b_in == '0)
                            begin
                                st_next    = ialu_pkg::ST_DIVZ;
                                state_next = S_DONE;
                            end
                            else
                                state_next = S_ABSA;
                        end
                        ialu_pkg::OP_GCD, ialu_pkg::OP_LCM:
                        begin
                            if (a_in == '0 || b_in == '0 || a_in[DW-1] || b_in[DW-1])
                            begin
                                st_next    = ialu_pkg::ST_NONPOS;
                                state_next = S_DONE;
                            end
                            else
                                state_next = S_GTWO;
                        end
                        default:
                            state_next = S_DONE;
                    endcase
                end
            end
            S_ARITH:
            begin
                z_next     = us[DW-1:0];
                state_next = S_DONE;
            end
            S_ABSA:
            begin
                if (neg_a)
                    x_next = us[DW-1:0];
                state_next = S_ABSB;
            end
            S_ABSB:
            begin
                if (neg_b)
                    y_next = us[DW-1:0];
                state_next = S_DIV;
            end
            S_DIV:
            begin
                z_next   = qbit ? us[DW-1:0] : {z_reg[DW-2:0], x_reg[DW-1]};
                x_next   = {x_reg[DW-2:0], qbit};
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(DW - 1))
                begin
                    if (op_reg == ialu_pkg::OP_LCM)
                    begin
                        z_next     = '0;
                        y_next     = b_reg;
                        cnt_next   = '0;
                        state_next = S_MUL;
                    end
                    else
                        state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                z_next     = us[DW-1:0];
                state_next = S_DONE;
            end
            S_MUL:
            begin
                if (x_reg[0])
                    z_next = us[DW-1:0];
                x_next   = {1'b0, x_reg[DW-1:1]};
                y_next   = {y_reg[DW-2:0], 1'b0};
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(DW - 1))
                    state_next = S_DONE;
            end
            S_GTWO:
            begin
                if (!x_reg[0] && !y_reg[0])
                begin
                    x_next  = {1'b0, x_reg[DW-1:1]};
                    y_next  = {1'b0, y_reg[DW-1:1]};
                    sh_next = sh_reg + CW'(1);
                end
                else
                    state_next = S_GODD;
            end
            S_GODD:
            begin
                if (!x_reg[0])
                    x_next = {1'b0, x_reg[DW-1:1]};
                else
                    state_next = S_GLOOP;
            end
            S_GLOOP:
            begin
                priority if (y_reg == '0)
                    state_next = S_GSHL;
                else if (!y_reg[0])
                    y_next = {1'b0, y_reg[DW-1:1]};
                else if (us[DW])
                begin
                    x_next = y_reg;
                    y_next = x_reg;
                end
                else
                    y_next = us[DW-1:0];
            end
            S_GSHL:
            begin
                if (sh_reg == '0)
                begin
                    if (op_reg == ialu_pkg::OP_GCD)
                    begin
                        z_next     = x_reg;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        x_next     = a_reg;
                        y_next     = x_reg;
                        z_next     = '0;
                        cnt_next   = '0;
                        state_next = S_DIV;
                    end
                end
                else
                begin
                    x_next  = {x_reg[DW-2:0], 1'b0};
                    sh_next = sh_reg - CW'(1);
                end
            end
            S_DONE:
            begin
                if (ctl.take)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            sh_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            sh_reg    <= sh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        st_reg <= st_next;
        a_reg  <= a_next;
        b_reg  <= b_next;
        x_reg  <= x_next;
        y_reg  <= y_next;
        z_reg  <= z_next;
    end

    assign z_ext            = {32'b0, z_reg};
    assign rsp.result_value = z_ext[31:0];
    assign rsp.status_code  = st_reg;
    assign sts.idle         = (state_reg == S_IDLE);
    assign sts.done         = (state_reg == S_DONE);

endmodule

`default_nettype wire

// ===== hdl/integer_alu_with_gcd_lcm_core.sv =====
// All operations use the single shared add/subtract unit. Multiply shifts and adds;
// quotient/remainder divide absolute values and fix the sign; gcd is binary,
// data dependent; lcm is a over the gcd, times b. Errors and unused opcode go to done.
// One request in flight; the next is taken once the result moves to the output register.
// Reset is asynchronous, active low, and clears the sequencer and output valid.
// Top level of the integer ALU; instantiates ialu_engine and uses ialu_pkg.
`default_nettype none

module integer_alu_with_gcd_lcm_core #(
    parameter int DATA_WIDTH = ialu_pkg::DATA_WIDTH_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  req_valid,
    output logic                 req_ready,
    input  ialu_pkg::ialu_req_t  req,
    output logic                 rsp_valid,
    input  wire                  rsp_ready,
    output ialu_pkg::ialu_rsp_t  rsp
);

    ialu_pkg::ialu_ctl_t ctl;
    ialu_pkg::ialu_sts_t sts;
    ialu_pkg::ialu_rsp_t eng_rsp;
    ialu_pkg::ialu_rsp_t rsp_reg;
    logic                rsp_valid_reg, rsp_valid_next;

    ialu_engine #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .req   (req),
        .sts   (sts),
        .rsp   (eng_rsp)
    );

    assign req_ready = sts.idle;
    assign ctl.start = req_valid && sts.idle;
    assign ctl.take  = sts.done && (!rsp_valid_reg || rsp_ready);

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        priority if (ctl.take)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else
            rsp_valid_reg <= rsp_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.take)
            rsp_reg <= eng_rsp;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef NO_ASSERTIONS
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted but engine still idle");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        sts.done && !ctl.take |=> sts.done)
        else $error("result dropped before handoff");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.status_code != ialu_pkg::ST_UNUSED)
        else $error("unused status code");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status_code != ialu_pkg::ST_OK |-> rsp.result_value == '0)
        else $error("error result not zero");
`endif

endmodule

`default_nettype wire
